[sv/hcpc_pkg.sv]
// Package: rule-string table, cell encoding and the one-generation automaton step.
`timescale 1ns / 1ps
package hcpc_pkg;

  // Fixed field widths
  localparam int CELLS       = 8;
  localparam int KEY_W       = 4;
  localparam int RULE_IDX_W  = KEY_W + 1;
  localparam int RULE_COUNT  = 1 << RULE_IDX_W;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // Default number of automaton generations
  localparam int GENERATIONS_DEF = 7;

  // Register indexes
  localparam logic REG_DECRYPT_MODE = 1'b0;

  // Cell source codes
  localparam logic [1:0] SRC_LEFT  = 2'd0;
  localparam logic [1:0] SRC_RIGHT = 2'd1;
  localparam logic [1:0] SRC_SELF  = 2'd2;

  // Rule letters as ASCII codes
  localparam logic [7:0] LTR_A_UP = "A";
  localparam logic [7:0] LTR_A_LO = "a";
  localparam logic [7:0] LTR_C_UP = "C";
  localparam logic [7:0] LTR_C_LO = "c";
  localparam logic [7:0] LTR_B_UP = "B";
  localparam logic [7:0] LTR_B_LO = "b";

  typedef logic [CELLS-1:0] cell_byte_t;

  typedef struct packed {
    logic [1:0] src;
    logic       inv;
  } cell_t;

  // One cell per bit, indexed by bit number (bit 7 is string position 0)
  typedef cell_t [CELLS-1:0] rule_t;

  // Rule strings indexed by {key nibble, mode}; first letter sits in the top byte
  localparam logic [8*CELLS-1:0] RULE_TEXT [RULE_COUNT] = '{
    "AAAaaAaa", "CCccCccC", "AaaAaaAA", "ccCccCCC",
    "aAaaAAAa", "CccCCCcc", "aaAAAaaA", "cCCCccCc",
    "CCcCCccc", "aAAaAAaa", "ccCCcCCc", "aaaAAaAA",
    "CcccCCcC", "AAaaaAAa", "cCCcccCC", "AaAAaaaA",
    "BBbBCaca", "BBbBcAca", "bcABcABb", "bCaBCaBb",
    "CabbBCaB", "cAbbBcAB", "bBCabbCA", "bBcAbbCA",
    "bcACAbbB", "bCaCAbbB", "bBbcACAb", "bBbCaCAb",
    "CABcaBbb", "CABcaBbb", "BbcAbcAB", "BbCabCaB"
  };

  // Decode one rule letter into a cell control
  function automatic cell_t letter_to_cell(input logic [7:0] ch);
    cell_t c;
    case (ch)
      LTR_A_UP: c = '{src: SRC_LEFT,  inv: 1'b0};
      LTR_A_LO: c = '{src: SRC_LEFT,  inv: 1'b1};
      LTR_C_UP: c = '{src: SRC_RIGHT, inv: 1'b0};
      LTR_C_LO: c = '{src: SRC_RIGHT, inv: 1'b1};
      LTR_B_UP: c = '{src: SRC_SELF,  inv: 1'b0};
      LTR_B_LO: c = '{src: SRC_SELF,  inv: 1'b1};
      default:  c = '{src: SRC_SELF,  inv: 1'b0};
    endcase
    return c;
  endfunction

  // Look up the rule for a {key nibble, mode} index
  function automatic rule_t rule_lookup(input logic [RULE_IDX_W-1:0] idx);
    rule_t r;
    logic [8*CELLS-1:0] txt;
    txt = RULE_TEXT[idx];
    for (int b = 0; b < CELLS; b++) begin
      r[b] = letter_to_cell(txt[b*8 +: 8]);
    end
    return r;
  endfunction

  // One generation over a cyclic byte: left neighbor is the next higher bit
  function automatic cell_byte_t ca_step(input cell_byte_t x, input rule_t r);
    cell_byte_t y;
    logic v;
    for (int b = 0; b < CELLS; b++) begin
      case (r[b].src)
        SRC_LEFT:  v = x[3'(b + 1)];
        SRC_RIGHT: v = x[3'(b + CELLS - 1)];
        default:   v = x[b];
      endcase
      y[b] = v ^ r[b].inv;
    end
    return y;
  endfunction

endpackage

[sv/hcpc_lane.sv]
// One channel lane: a pipeline of automaton generations, one generation per stage.
`timescale 1ns / 1ps
module hcpc_lane #(
  parameter int GENERATIONS = hcpc_pkg::GENERATIONS_DEF
) (
  input  logic                                  clk,
  input  logic [GENERATIONS-1:0]                stage_load,
  input  hcpc_pkg::rule_t [GENERATIONS-1:0]     stage_rule,
  input  hcpc_pkg::cell_byte_t                  byte_in,
  output hcpc_pkg::cell_byte_t                  byte_out
);
  import hcpc_pkg::*;

  cell_byte_t data_r   [GENERATIONS];
  cell_byte_t data_nxt [GENERATIONS];
  cell_byte_t stage_q  [GENERATIONS];

  genvar k;
  generate
    for (k = 0; k < GENERATIONS; k++) begin : g_stage
      // Apply one generation to what this stage holds
      assign stage_q[k] = ca_step(data_r[k], stage_rule[k]);

      // Pick the stage input: the pixel byte or the previous stage's result
      if (k == 0) begin : g_first
        assign data_nxt[k] = byte_in;
      end else begin : g_rest
        assign data_nxt[k] = stage_q[k-1];
      end

      // Load when the stage advances, hold otherwise
      always_ff @(posedge clk) begin
        if (stage_load[k]) begin
          data_r[k] <= data_nxt[k];
        end
      end
    end
  endgenerate

  assign byte_out = stage_q[GENERATIONS-1];

endmodule

[sv/hcpc_merge.sv]
// Output stage: gathers the three lane results into one registered result item.
`timescale 1ns / 1ps
module hcpc_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 last_valid,
  input  hcpc_pkg::cell_byte_t red_q,
  input  hcpc_pkg::cell_byte_t green_q,
  input  hcpc_pkg::cell_byte_t blue_q,
  output logic                 out_space,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata    // red_out[7:0], green_out[15:8], blue_out[23:16]
);
  import hcpc_pkg::*;

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [23:0] out_data_r;
  logic        load;

  // Room for a new item when empty or when the held one leaves now
  assign out_space = !out_valid_r || out_tready;
  assign load      = last_valid && out_space;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_space) begin
      out_valid_nxt = last_valid;
    end
  end

  // Clear the valid flag under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Pack the lanes, red in the low byte
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {blue_q, green_q, red_q};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[sv/hybrid_ca_pixel_cipher.sv]
// Top level: hybrid cellular-automaton pixel cipher with three channel lanes.
// Each pixel item runs through GENERATIONS pipeline stages, one automaton
// generation per stage, in three identical lanes (red, green, blue) that share
// the rule selected by the key nibble and decrypt_mode; an output register then
// packs the three bytes into one result item. The block takes one item every
// cycle while the pipeline has room. The accepting edge loads the first stage
// register, and the item then passes the remaining GENERATIONS - 1 stage
// registers and the output register before out_tvalid rises. A stall at the
// output fills bubbles in the pipeline first, so input items keep being taken
// until every stage is full.
// decrypt_mode sits at byte address 0 of the APB port and is read back there.
`timescale 1ns / 1ps
module hybrid_ca_pixel_cipher #(
  parameter int GENERATIONS = hcpc_pkg::GENERATIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // red_in[7:0], green_in[15:8],
                                                      // blue_in[23:16], rule_set[27:24]
  // Result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // red_out[7:0], green_out[15:8],
                                                      // blue_out[23:16]
  // Configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [hcpc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [hcpc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [hcpc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import hcpc_pkg::*;

  logic                      decrypt_mode_r;
  logic                      decrypt_mode_nxt;
  logic                      cfg_wr;
  logic                      reg_sel;

  logic [GENERATIONS-1:0]    valid_r;
  logic [GENERATIONS-1:0]    valid_nxt;
  logic [GENERATIONS-1:0]    prev_valid;
  logic [GENERATIONS:0]      space;
  rule_t [GENERATIONS-1:0]   rule_r;
  rule_t [GENERATIONS-1:0]   rule_nxt;
  rule_t                     in_rule;
  logic                      out_space;

  cell_byte_t                red_q;
  cell_byte_t                green_q;
  cell_byte_t                blue_q;

  // Configuration write and read-back
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[CFG_ADDR_W-1];

  always_comb begin
    decrypt_mode_nxt = decrypt_mode_r;
    if (cfg_wr && (reg_sel == REG_DECRYPT_MODE)) begin
      decrypt_mode_nxt = cfg_pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_mode_r <= 1'b0;
    end else begin
      decrypt_mode_r <= decrypt_mode_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_sel == REG_DECRYPT_MODE) begin
      cfg_prdata[0] = decrypt_mode_r;
    end
  end

  // Select the rule for the incoming item
  assign in_rule = rule_lookup({in_tdata[24 +: KEY_W], decrypt_mode_r});

  // Stage control: a stage loads when empty or when the next one takes its item
  assign space[GENERATIONS] = out_space;
  assign in_tready          = space[0];

  genvar k;
  generate
    for (k = 0; k < GENERATIONS; k++) begin : g_ctl
      assign space[k] = !valid_r[k] || space[k+1];

      if (k == 0) begin : g_first
        assign prev_valid[k] = in_tvalid;
        assign rule_nxt[k]   = in_rule;
      end else begin : g_rest
        assign prev_valid[k] = valid_r[k-1];
        assign rule_nxt[k]   = rule_r[k-1];
      end

      assign valid_nxt[k] = space[k] ? prev_valid[k] : valid_r[k];

      // Advance the rule alongside the item
      always_ff @(posedge clk) begin
        if (space[k]) begin
          rule_r[k] <= rule_nxt[k];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Three channel lanes
  hcpc_lane #(.GENERATIONS(GENERATIONS)) u_lane_red (
    .clk        (clk),
    .stage_load (space[GENERATIONS-1:0]),
    .stage_rule (rule_r),
    .byte_in    (in_tdata[7:0]),
    .byte_out   (red_q)
  );

  hcpc_lane #(.GENERATIONS(GENERATIONS)) u_lane_green (
    .clk        (clk),
    .stage_load (space[GENERATIONS-1:0]),
    .stage_rule (rule_r),
    .byte_in    (in_tdata[15:8]),
    .byte_out   (green_q)
  );

  hcpc_lane #(.GENERATIONS(GENERATIONS)) u_lane_blue (
    .clk        (clk),
    .stage_load (space[GENERATIONS-1:0]),
    .stage_rule (rule_r),
    .byte_in    (in_tdata[23:16]),
    .byte_out   (blue_q)
  );

  // Merge the lanes into the result register
  hcpc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .last_valid (valid_r[GENERATIONS-1]),
    .red_q      (red_q),
    .green_q    (green_q),
    .blue_q     (blue_q),
    .out_space  (out_space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Input is refused only when every stage and the output register are full
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> ((&valid_r) && out_tvalid && !out_tready))
    else $error("input stalled with room in the pipeline");

  // An accepted item occupies the first stage next cycle
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> valid_r[0])
    else $error("accepted item lost at first stage");

  // The mode changes only through a configuration write
  a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr |=> $stable(decrypt_mode_r))
    else $error("decrypt_mode changed without a write");

  // A full last stage under an output stall keeps its item
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[GENERATIONS-1] && !out_space) |=> valid_r[GENERATIONS-1])
    else $error("last stage dropped an item under stall");

endmodule

[bench/hybrid_ca_pixel_cipher_tb.sv]
// Testbench: random and directed pixel streams through the cipher, checked against a CA predictor.
`timescale 1ns / 1ps

localparam int CA_GENERATIONS = 7;

// Red sits in the low byte, as on the result bus
typedef struct packed {
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
} pixel_t;

class pixel_scoreboard;
  // Rule letters
  localparam logic [7:0] LTR_LEFT      = "A";
  localparam logic [7:0] LTR_LEFT_INV  = "a";
  localparam logic [7:0] LTR_RIGHT     = "C";
  localparam logic [7:0] LTR_RIGHT_INV = "c";
  localparam logic [7:0] LTR_SELF_INV  = "b";

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // Rule strings per [key nibble][mode]; first letter (bit 7) in the top byte
  logic [63:0] rule_text [16][2];
  logic        mode;
  pixel_t      expected_q [$];
  int unsigned errors;
  int unsigned pixels_per_mode [2];
  int unsigned checked;
  int unsigned reg_writes;

  function new();
    rule_text = '{
      '{"AAAaaAaa", "CCccCccC"}, '{"AaaAaaAA", "ccCccCCC"},
      '{"aAaaAAAa", "CccCCCcc"}, '{"aaAAAaaA", "cCCCccCc"},
      '{"CCcCCccc", "aAAaAAaa"}, '{"ccCCcCCc", "aaaAAaAA"},
      '{"CcccCCcC", "AAaaaAAa"}, '{"cCCcccCC", "AaAAaaaA"},
      '{"BBbBCaca", "BBbBcAca"}, '{"bcABcABb", "bCaBCaBb"},
      '{"CabbBCaB", "cAbbBcAB"}, '{"bBCabbCA", "bBcAbbCA"},
      '{"bcACAbbB", "bCaCAbbB"}, '{"bBbcACAb", "bBbCaCAb"},
      '{"CABcaBbb", "CABcaBbb"}, '{"BbcAbcAB", "BbCabCaB"}
    };
    mode = MODE_ENCRYPT;
    errors = 0;
    pixels_per_mode = '{0, 0};
    checked = 0;
    reg_writes = 0;
  endfunction

  // One generation: every cell looks at the previous byte only
  function logic [7:0] ca_generation(logic [7:0] x, logic [63:0] letters);
    logic [7:0] lft;
    logic [7:0] rgt;
    logic [7:0] y;
    logic [7:0] ch;
    logic       v;
    lft = {x[0], x[7:1]};
    rgt = {x[6:0], x[7]};
    for (int b = 0; b < 8; b++) begin
      ch = letters[8*b +: 8];
      if (ch == LTR_LEFT || ch == LTR_LEFT_INV) v = lft[b];
      else if (ch == LTR_RIGHT || ch == LTR_RIGHT_INV) v = rgt[b];
      else v = x[b];
      if (ch == LTR_LEFT_INV || ch == LTR_RIGHT_INV || ch == LTR_SELF_INV) v = ~v;
      y[b] = v;
    end
    return y;
  endfunction

  function logic [7:0] ca_scramble(logic [7:0] x, logic [63:0] letters);
    logic [7:0] s;
    s = x;
    for (int g = 0; g < CA_GENERATIONS; g++) s = ca_generation(s, letters);
    return s;
  endfunction

  function void note_config(int index, logic [31:0] value);
    reg_writes++;
    if (index == int'(hcpc_pkg::REG_DECRYPT_MODE)) mode = value[0];
  endfunction

  // Predict the result of one accepted pixel
  function void note_pixel(pixel_t px, logic [3:0] key);
    pixel_t exp_px;
    logic [63:0] letters;
    letters = rule_text[key][mode];
    exp_px.red   = ca_scramble(px.red, letters);
    exp_px.green = ca_scramble(px.green, letters);
    exp_px.blue  = ca_scramble(px.blue, letters);
    expected_q = {expected_q, exp_px};
    pixels_per_mode[mode]++;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 20) $display("MISMATCH: %s", msg);
  endtask

  // Compare one result item against the oldest prediction
  task check_pixel(pixel_t got);
    pixel_t exp_px;
    if (expected_q.size() == 0) begin
      report($sformatf("result %06h with no pixel outstanding", got));
    end else begin
      exp_px = expected_q.pop_front();
      checked++;
      if (got.red !== exp_px.red)
        report($sformatf("result %0d red %02h, expected %02h", checked, got.red, exp_px.red));
      if (got.green !== exp_px.green)
        report($sformatf("result %0d green %02h, expected %02h", checked, got.green,
                         exp_px.green));
      if (got.blue !== exp_px.blue)
        report($sformatf("result %0d blue %02h, expected %02h", checked, got.blue,
                         exp_px.blue));
    end
  endtask
endclass

module hybrid_ca_pixel_cipher_tb;
  localparam int          REG_UNUSED  = 1;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RAND_PHASES = 6;
  localparam int          PHASE_ITEMS = 125;
  localparam logic [7:0]  PATTERNS [8] = '{8'h00, 8'hFF, 8'h01, 8'h80,
                                           8'h55, 8'hAA, 8'h0F, 8'hF0};

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [31:0]                     in_tdata;   // red[7:0], green[15:8], blue[23:16], key[27:24]
  logic                            out_tvalid;
  logic                            out_tready;
  logic [23:0]                     out_tdata;  // red[7:0], green[15:8], blue[23:16]
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [hcpc_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [hcpc_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [hcpc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  pixel_scoreboard sb = new();
  logic            calm = 1'b0;
  int unsigned     cycle_count = 0;
  int unsigned     stall_left = 0;

  hybrid_ca_pixel_cipher #(.GENERATIONS(CA_GENERATIONS)) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [7:0] channel_value();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'(1 << $urandom_range(7));
      default: return 8'($urandom);
    endcase
  endfunction

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Take results with random back-pressure
  initial out_tready <= 1'b0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      stall_left = idle_len();
      out_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Send one pixel; leave tvalid high so a back-to-back item follows without a bubble
  task send_pixel(pixel_t px, logic [3:0] key, logic [3:0] junk);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {junk, key, px};
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(px, key);
  endtask

  task send_random();
    pixel_t px;
    px.red   = channel_value();
    px.green = channel_value();
    px.blue  = channel_value();
    send_pixel(px, 4'($urandom_range(15)), 4'($urandom));
  endtask

  // Stop sending and wait for every outstanding result
  task drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Two-phase register write; the register takes it at the access edge, and the bus then returns to idle
  task cfg_write(int index, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= hcpc_pkg::CFG_ADDR_W'(4 * index);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.note_config(index, value);
    @(posedge clk);
  endtask

  initial begin
    pixel_t px;
    logic   mode_bit;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every key nibble in encrypt mode with extreme channel bytes
    for (int k = 0; k < 16; k++) begin
      px.red   = PATTERNS[k % 8];
      px.green = ~PATTERNS[k % 8];
      px.blue  = PATTERNS[(k + 3) % 8];
      send_pixel(px, 4'(k), k[0] ? 4'hF : 4'h0);
    end
    drain();

    // Decrypt with junk in the upper data bits, then a write to an unused register
    cfg_write(int'(hcpc_pkg::REG_DECRYPT_MODE), 32'h8000_0001);
    cfg_write(REG_UNUSED, 32'h0000_0000);
    for (int k = 8; k < 16; k++) begin
      px.red   = PATTERNS[(k + 1) % 8];
      px.green = PATTERNS[k % 8];
      px.blue  = ~PATTERNS[(k + 5) % 8];
      send_pixel(px, 4'(k), k[0] ? 4'h0 : 4'hF);
    end

    // Random phases, each under its own register setting
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      mode_bit = (phase < 2) ? phase[0] : 1'($urandom);
      cfg_write(int'(hcpc_pkg::REG_DECRYPT_MODE), {31'($urandom), mode_bit});
      if ($urandom_range(1)) cfg_write(REG_UNUSED, $urandom);
      calm = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == PHASE_ITEMS / 2) drain();
        send_random();
      end
    end
    calm = 1'b0;

    // Let the pipeline empty, then watch for stray results
    drain();
    repeat (4 * (CA_GENERATIONS + 2)) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Checked %0d pixels (encrypt %0d, decrypt %0d) across %0d register writes,",
             sb.checked, sb.pixels_per_mode[0], sb.pixels_per_mode[1], sb.reg_writes);
    $display("all key nibbles, extreme bytes and output stalls; %0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[sim.f]
sv/hcpc_pkg.sv
sv/hcpc_lane.sv
sv/hcpc_merge.sv
sv/hybrid_ca_pixel_cipher.sv
bench/hybrid_ca_pixel_cipher_tb.sv
